>>> hw/rtl/lbc_pkg.sv
// Package for the LCD bar column renderer: payload structs, microcode word
// layout, the microcode program and display command constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

  // Display controller command and mask constants
  localparam logic [7:0] CMD_PAGE         = 8'hB0;
  localparam logic [7:0] CMD_COL_HI       = 8'h10;
  localparam logic [7:0] NIBBLE_LO        = 8'h0F;
  localparam logic [7:0] NIBBLE_HI        = 8'hF0;
  localparam logic [7:0] BYTE_FULL        = 8'hFF;
  localparam logic [7:0] BYTE_BLANK       = 8'h00;
  localparam logic [7:0] COL_OFFSET_RESET = 8'd4;
  localparam logic [3:0] MAX_PAGES        = 4'd8;

  // Microprogram step addresses
  localparam logic [2:0] STEP_IDLE   = 3'd0;
  localparam logic [2:0] STEP_PAGE   = 3'd1;
  localparam logic [2:0] STEP_COL_HI = 3'd2;
  localparam logic [2:0] STEP_COL_LO = 3'd3;
  localparam logic [2:0] STEP_DATA   = 3'd4;
  localparam logic [2:0] STEP_CLOSE  = 3'd5;
  localparam logic [2:0] STEP_CL_HI  = 3'd6;
  localparam logic [2:0] STEP_CL_LO  = 3'd7;

  typedef struct packed {
    logic [6:0] start_column;
    logic [2:0] start_page;
    logic [3:0] bar_pages;
    logic [7:0] level;
  } req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;
  } res_t;

  // Per-request values derived at accept time
  typedef struct packed {
    logic [3:0] pages;
    logic [2:0] mark;
    logic [3:0] shift;
  } setup_t;

  typedef enum logic [1:0] {
    SRC_PAGE,
    SRC_COL_HI,
    SRC_COL_LO,
    SRC_DATA
  } byte_src_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_START,
    JMP_LOOP,
    JMP_ALWAYS
  } jmp_t;

  typedef struct packed {
    logic       emit;        // step sends one byte
    byte_src_t  src;         // byte source
    logic       start_page;  // page command uses start page instead of current page
    logic       next_col;    // column commands use column + 1
    logic       last;        // byte closes the run
    jmp_t       jmp;         // sequencing condition
    logic [2:0] target;      // jump target
  } ucode_t;

  // Microprogram: per page a cursor triple and a data byte, then the closing triple
  function automatic ucode_t lbc_ucode(input logic [2:0] step);
    ucode_t cw;
    cw = '{emit: 1'b0, src: SRC_PAGE, start_page: 1'b0, next_col: 1'b0,
           last: 1'b0, jmp: JMP_START, target: STEP_PAGE};
    case (step)
      STEP_IDLE: begin
        cw = '{1'b0, SRC_PAGE, 1'b0, 1'b0, 1'b0, JMP_START, STEP_PAGE};
      end
      STEP_PAGE: begin
        cw = '{1'b1, SRC_PAGE, 1'b0, 1'b0, 1'b0, JMP_NEXT, STEP_IDLE};
      end
      STEP_COL_HI: begin
        cw = '{1'b1, SRC_COL_HI, 1'b0, 1'b0, 1'b0, JMP_NEXT, STEP_IDLE};
      end
      STEP_COL_LO: begin
        cw = '{1'b1, SRC_COL_LO, 1'b0, 1'b0, 1'b0, JMP_NEXT, STEP_IDLE};
      end
      STEP_DATA: begin
        cw = '{1'b1, SRC_DATA, 1'b0, 1'b0, 1'b0, JMP_LOOP, STEP_PAGE};
      end
      STEP_CLOSE: begin
        cw = '{1'b1, SRC_PAGE, 1'b1, 1'b1, 1'b0, JMP_NEXT, STEP_IDLE};
      end
      STEP_CL_HI: begin
        cw = '{1'b1, SRC_COL_HI, 1'b1, 1'b1, 1'b0, JMP_NEXT, STEP_IDLE};
      end
      STEP_CL_LO: begin
        cw = '{1'b1, SRC_COL_LO, 1'b1, 1'b1, 1'b1, JMP_ALWAYS, STEP_IDLE};
      end
      default: begin
        cw = '{1'b0, SRC_PAGE, 1'b0, 1'b0, 1'b0, JMP_START, STEP_PAGE};
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lbc_setup.sv
// Request setup logic: clamps bar height and level, derives mark page and
// mark-page shift. Depends on lbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbc_setup (
  input  lbc_pkg::req_t   req,
  output lbc_pkg::setup_t setup
);
  import lbc_pkg::*;

  logic [3:0] pages;
  logic [6:0] height;
  logic [6:0] level_c;
  logic       full;
  logic [6:0] gap;

  // Clamp height to eight pages and level to the bar height
  always_comb begin
    pages   = (req.bar_pages > MAX_PAGES) ? MAX_PAGES : req.bar_pages;
    height  = {pages, 3'b000};
    full    = (req.level >= {1'b0, height});
    // Below a full bar the level is under the height, so seven bits hold it
    level_c = full ? height : req.level[6:0];
    // Empty pixels above the fill, minus one; only meaningful when not full
    gap     = height - 7'd1 - level_c;
  end

  // Mark page and shift of the partial byte
  always_comb begin
    setup.pages = pages;
    if (full) begin
      setup.mark  = 3'd0;
      setup.shift = 4'd0;
    end else begin
      setup.mark  = gap[5:3];
      setup.shift = {1'b0, gap[2:0]} + 4'd1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcd_bar_column_renderer.sv
// After a request is accepted the step register moves to the first emitting
// step, whose byte then loads the output register. Throughput: 4*pages+3 bytes
// per request (3 to 35), one byte per cycle while the output is taken; the
// program returns to the idle step before the next request. The step counter
// of the microcode program sets the byte rate. Reset: synchronous active-high
// rst returns to idle, drops any pending byte and sets column_offset to 4.
`timescale 1ns / 1ps
`default_nettype none

module lcd_bar_column_renderer (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  logic          req_valid,
  output logic          req_ready,
  input  lbc_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output lbc_pkg::res_t res
);
  import lbc_pkg::*;

  logic [7:0] column_offset;
  logic [2:0] step;
  logic [2:0] step_next;
  logic [2:0] idx;
  logic [2:0] idx_next;
  logic [3:0] pages;
  logic [2:0] mark;
  logic [3:0] shift;
  logic [2:0] page0;
  logic [7:0] col;

  setup_t     setup;
  ucode_t     cw;
  logic       accept;
  logic       out_load;
  logic       advance;
  logic       loop_more;
  logic [7:0] col_sel;
  logic [7:0] page_byte;
  logic [7:0] data_byte;
  logic [7:0] byte_sel;

  lbc_setup u_setup (
    .req   (req),
    .setup (setup)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= COL_OFFSET_RESET;
    end else if (cfg_we) begin
      column_offset <= cfg_data;
    end
  end

  // Fetch control word and decide whether the step completes
  always_comb begin
    cw        = lbc_ucode(step);
    req_ready = (cw.jmp == JMP_START);
    accept    = req_valid && req_ready;
    out_load  = cw.emit && (!res_valid || res_ready);
    advance   = cw.emit ? out_load : accept;
    loop_more = (({1'b0, idx} + 4'd1) < pages);
  end

  // Sequence: next step and page index
  always_comb begin
    step_next = step;
    idx_next  = idx;
    if (advance) begin
      case (cw.jmp)
        JMP_NEXT: begin
          step_next = step + 3'd1;
        end
        JMP_START: begin
          step_next = (setup.pages == 4'd0) ? STEP_CLOSE : cw.target;
          idx_next  = 3'd0;
        end
        JMP_LOOP: begin
          if (loop_more) begin
            step_next = cw.target;
            idx_next  = idx + 3'd1;
          end else begin
            step_next = step + 3'd1;
          end
        end
        JMP_ALWAYS: begin
          step_next = cw.target;
        end
        default: begin
          step_next = STEP_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Hold request values for the whole run
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      pages <= setup.pages;
      mark  <= setup.mark;
      shift <= setup.shift;
      page0 <= req.start_page;
      col   <= {1'b0, req.start_column} + column_offset;
    end
  end

  // Datapath: form the byte the control word selects
  always_comb begin
    col_sel   = cw.next_col ? (col + 8'd1) : col;
    page_byte = CMD_PAGE + {5'd0, page0} + (cw.start_page ? 8'd0 : {5'd0, idx});
    if (idx < mark) begin
      data_byte = BYTE_BLANK;
    end else if (idx > mark) begin
      data_byte = BYTE_FULL;
    end else begin
      data_byte = BYTE_FULL << shift;
    end
    case (cw.src)
      SRC_PAGE:   byte_sel = page_byte;
      SRC_COL_HI: byte_sel = CMD_COL_HI | ((col_sel & NIBBLE_HI) >> 4);
      SRC_COL_LO: byte_sel = col_sel & NIBBLE_LO;
      SRC_DATA:   byte_sel = data_byte;
      default:    byte_sel = BYTE_BLANK;
    endcase
  end

  // Output register: load a byte when the slot is free or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.is_data  <= (cw.src == SRC_DATA);
      res.lcd_byte <= byte_sel;
      res.last     <= cw.last;
    end
  end

  // A closing byte is always a command
  a_last_is_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |-> !res.is_data)
    else $error("last byte flagged as data");

  // A stalled output freezes the program
  a_stall_holds_step: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready && cw.emit |=> $stable(step))
    else $error("step advanced while output stalled");

  // An accepted request starts at a page triple or the closing triple
  a_start_target: assert property (@(posedge clk) disable iff (rst)
    accept |=> (step == STEP_PAGE) || (step == STEP_CLOSE))
    else $error("bad first step after accept");

  // Page index stays inside the bar while drawing pages
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (step != STEP_IDLE) && (pages != 4'd0) |-> ({1'b0, idx} < pages))
    else $error("page index beyond bar height");

  // Data bytes load only in the step after a low-nibble command or in a held data step
  a_data_follows_col: assert property (@(posedge clk) disable iff (rst)
    out_load && (cw.src == SRC_DATA) |-> $past(step) == STEP_COL_LO || $past(step) == STEP_DATA)
    else $error("data byte out of sequence");

endmodule

`default_nettype wire
